[hw/rtl/wtt_pkg.sv]
package wtt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 7;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = (CNT_W > 3) ? CNT_W : 3;
  localparam int unsigned TIME_W   = 20;

  // Time constants
  localparam logic [TIME_W-1:0] SEC_PER_DAY  = TIME_W'(86400);
  localparam logic [TIME_W-1:0] SEC_PER_HOUR = TIME_W'(3600);
  localparam logic [TIME_W-1:0] SEC_PER_MIN  = TIME_W'(60);
  localparam logic [TIME_W-1:0] HALF_HOUR    = TIME_W'(1800);
  localparam logic [TIME_W-1:0] PRESET_HOUR  = TIME_W'(22);
  localparam int unsigned       PRESET_COUNT = 4;
  localparam int unsigned       RESET_COUNT  =
      (CAPACITY < PRESET_COUNT) ? CAPACITY : PRESET_COUNT;

  // Request kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef logic [TIME_W-1:0] wtt_time_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic append;
    logic erase_start;
    logic shift;
    logic shrink;
    logic calc;
    logic scan_next;
    logic hit_set;
    logic shift_mode;
    logic out_load;
  } wtt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       idx_ok;
    logic       shift_more;
    logic       scan_more;
    logic       hit;
  } wtt_sts_t;

  // Preset window starts after reset
  function automatic wtt_time_t preset_on(input int unsigned idx);
    wtt_time_t t;
    case (idx)
      0:       t = TIME_W'(3) * SEC_PER_DAY + PRESET_HOUR * SEC_PER_HOUR;
      1:       t = TIME_W'(5) * SEC_PER_DAY + PRESET_HOUR * SEC_PER_HOUR;
      2:       t = TIME_W'(6) * SEC_PER_DAY + PRESET_HOUR * SEC_PER_HOUR;
      3:       t = PRESET_HOUR * SEC_PER_HOUR;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Preset window ends after reset
  function automatic wtt_time_t preset_off(input int unsigned idx);
    wtt_time_t t;
    case (idx)
      0:       t = TIME_W'(4) * SEC_PER_DAY;
      1:       t = TIME_W'(6) * SEC_PER_DAY + HALF_HOUR;
      2:       t = HALF_HOUR;
      3:       t = TIME_W'(23) * SEC_PER_HOUR + HALF_HOUR;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/wtt_if.sv]
// Request channel: one table operation
interface wtt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [19:0] on_time;
  logic [19:0] off_time;
  logic [2:0]  entry_index;
  logic [2:0]  day_of_week;
  logic [4:0]  hour_now;
  logic [5:0]  minute_now;
  logic [5:0]  second_now;

  modport source (
    output valid, kind, on_time, off_time, entry_index,
           day_of_week, hour_now, minute_now, second_now,
    input  ready
  );
  modport sink (
    input  valid, kind, on_time, off_time, entry_index,
           day_of_week, hour_now, minute_now, second_now,
    output ready
  );
endinterface

// Response channel: one result per request
interface wtt_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       active;
  logic [2:0] match_index;
  logic [2:0] entry_count;

  modport source (
    output valid, accepted, active, match_index, entry_count,
    input  ready
  );
  modport sink (
    input  valid, accepted, active, match_index, entry_count,
    output ready
  );
endinterface

[hw/rtl/weekly_time_window_table_core.sv]
// Channel  Dir  Modport  Fields
// req_i    in   sink     kind, on_time, off_time, entry_index, day/hour/minute/second
// rsp_o    out  source   accepted, active, match_index, entry_count
//
// One request at a time. Add and unused kinds go from decode straight to the response
// stage; a valid erase moves each entry above the erased one down in turn; query walks
// the table entries in order until the first hit or the end of the table, through the
// single table read port. The next request is taken in the cycle after the response
// is loaded. Reset is asynchronous and loads the four preset windows. A response
// waiting in the output register does not block the next request; only its completion
// waits for the response slot.
module weekly_time_window_table_core (
  input logic      clk_i,
  input logic      rst_ni,
  wtt_req_if.sink   req_i,
  wtt_rsp_if.source rsp_o
);
  import wtt_pkg::*;

  wtt_cmd_t cmd;
  wtt_sts_t sts;

  wtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wtt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (req_i.kind),
    .on_time_i     (req_i.on_time),
    .off_time_i    (req_i.off_time),
    .entry_index_i (req_i.entry_index),
    .day_of_week_i (req_i.day_of_week),
    .hour_now_i    (req_i.hour_now),
    .minute_now_i  (req_i.minute_now),
    .second_now_i  (req_i.second_now),
    .accepted_o    (rsp_o.accepted),
    .active_o      (rsp_o.active),
    .match_index_o (rsp_o.match_index),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule

[hw/rtl/wtt_ctrl.sv]
module wtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wtt_pkg::wtt_sts_t sts_i,
  output wtt_pkg::wtt_cmd_t cmd_o
);
  import wtt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence one request at a time
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        case (sts_i.kind)
          KIND_ADD: begin
            cmd_o.append = !sts_i.full;
          end
          KIND_ERASE: begin
            if (sts_i.idx_ok) begin
              cmd_o.erase_start = 1'b1;
              state_d           = S_SHIFT;
            end
          end
          KIND_QUERY: begin
            cmd_o.calc = 1'b1;
            state_d    = S_SCAN;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_SHIFT: begin
        cmd_o.shift_mode = 1'b1;
        if (sts_i.shift_more) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.shrink = 1'b1;
          state_d      = S_FIN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_more) begin
          state_d = S_FIN;
        end else if (sts_i.hit) begin
          cmd_o.hit_set = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the response until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/wtt_dp.sv]
module wtt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wtt_pkg::wtt_cmd_t cmd_i,
  output wtt_pkg::wtt_sts_t sts_o,
  input  logic [1:0]        kind_i,
  input  logic [19:0]       on_time_i,
  input  logic [19:0]       off_time_i,
  input  logic [2:0]        entry_index_i,
  input  logic [2:0]        day_of_week_i,
  input  logic [4:0]        hour_now_i,
  input  logic [5:0]        minute_now_i,
  input  logic [5:0]        second_now_i,
  output logic              accepted_o,
  output logic              active_o,
  output logic [2:0]        match_index_o,
  output logic [2:0]        entry_count_o
);
  import wtt_pkg::*;

  // Latched request
  logic [1:0]  kind_q;
  wtt_time_t   on_q, off_q;
  logic [2:0]  idx_q, day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q, sec_in_q;

  // Table and scan state
  wtt_time_t        start_q [CAPACITY];
  wtt_time_t        end_q   [CAPACITY];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] ptr_q;
  wtt_time_t        now_q;

  // Result under construction and output register
  logic             acc_q, act_q;
  logic [CNT_W-1:0] match_q;
  logic             out_acc_q, out_act_q;
  logic [2:0]       out_match_q, out_count_q;

  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  wtt_time_t        rd_on, rd_off, now_d;
  logic             wraps;

  assign ptr_inc = ptr_q + CNT_W'(1);
  assign rd_addr = cmd_i.shift_mode ? IDX_W'(ptr_inc) : IDX_W'(ptr_q);
  assign wr_addr = cmd_i.append ? IDX_W'(count_q) : IDX_W'(ptr_q);
  assign rd_on   = start_q[rd_addr];
  assign rd_off  = end_q[rd_addr];
  assign wraps   = (rd_off < rd_on);

  // Form the second of the week
  assign now_d = TIME_W'(day_q) * SEC_PER_DAY + TIME_W'(hour_q) * SEC_PER_HOUR
               + TIME_W'(min_q) * SEC_PER_MIN + TIME_W'(sec_in_q);

  // Status toward the controller
  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.full       = (count_q == CNT_W'(CAPACITY));
    sts_o.idx_ok     = (CMP_W'(idx_q) < CMP_W'(count_q));
    sts_o.shift_more = ({1'b0, ptr_q} + (CNT_W+1)'(1)) < {1'b0, count_q};
    sts_o.scan_more  = (ptr_q < count_q);
    sts_o.hit        = wraps ? ((now_q > rd_on) || (now_q < rd_off))
                             : ((now_q > rd_on) && (now_q < rd_off));
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      on_q     <= on_time_i;
      off_q    <= off_time_i;
      idx_q    <= entry_index_i;
      day_q    <= day_of_week_i;
      hour_q   <= hour_now_i;
      min_q    <= minute_now_i;
      sec_in_q <= second_now_i;
    end
    if (cmd_i.calc) begin
      now_q <= now_d;
    end
  end

  // Table storage: append at the tail, move entries down on erase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        start_q[i] <= preset_on(i);
        end_q[i]   <= preset_off(i);
      end
      count_q <= CNT_W'(RESET_COUNT);
    end else begin
      if (cmd_i.append) begin
        start_q[wr_addr] <= on_q;
        end_q[wr_addr]   <= off_q;
        count_q          <= count_q + CNT_W'(1);
      end else if (cmd_i.shift) begin
        start_q[wr_addr] <= rd_on;
        end_q[wr_addr]   <= rd_off;
      end else if (cmd_i.shrink) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Walk pointer and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      acc_q   <= 1'b0;
      act_q   <= 1'b0;
      match_q <= '0;
    end else begin
      if (cmd_i.load) begin
        acc_q   <= 1'b0;
        act_q   <= 1'b0;
        match_q <= '0;
      end
      if (cmd_i.append) begin
        acc_q <= 1'b1;
      end
      if (cmd_i.erase_start) begin
        acc_q <= 1'b1;
        ptr_q <= CNT_W'(idx_q);
      end
      if (cmd_i.calc) begin
        acc_q <= 1'b1;
        ptr_q <= '0;
      end
      if (cmd_i.shift || cmd_i.scan_next) begin
        ptr_q <= ptr_inc;
      end
      if (cmd_i.hit_set) begin
        act_q   <= 1'b1;
        match_q <= ptr_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_acc_q   <= acc_q;
      out_act_q   <= act_q;
      out_match_q <= 3'(match_q);
      out_count_q <= 3'(count_q);
    end
  end

  assign accepted_o    = out_acc_q;
  assign active_o      = out_act_q;
  assign match_index_o = out_match_q;
  assign entry_count_o = out_count_q;

endmodule

[hw/rtl/wtt_checker.sv]
module wtt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_accepted_i,
  input logic       rsp_active_i,
  input logic [2:0] rsp_match_index_i,
  input logic [2:0] rsp_entry_count_i
);

  // Stalled response stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // Stalled response payload holds
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_accepted_i) && $stable(rsp_active_i) &&
      $stable(rsp_match_index_i) && $stable(rsp_entry_count_i))
    else $error("response payload changed while stalled");

  // A taken request keeps the next one from being taken in the following cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken back to back");

  // A hit only comes from an accepted query
  a_active_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_active_i |-> rsp_accepted_i)
    else $error("active without accepted");

  // No hit means no match index
  a_no_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_active_i |-> rsp_match_index_i == 3'd0)
    else $error("match index set without a hit");

endmodule

bind weekly_time_window_table_core wtt_checker u_wtt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_accepted_i    (rsp_o.accepted),
  .rsp_active_i      (rsp_o.active),
  .rsp_match_index_i (rsp_o.match_index),
  .rsp_entry_count_i (rsp_o.entry_count)
);

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wtt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int DAY_S        = 86400;
  localparam int HOUR_S       = 3600;
  localparam int MIN_S        = 60;
  localparam int WEEK_LAST    = 7 * DAY_S - 1;
  localparam int RANDOM_ITEMS = 700;
  localparam int CALM_ITEMS   = 80;

  typedef struct packed {
    logic [1:0] kind;
    wtt_time_t  on_time;
    wtt_time_t  off_time;
    logic [2:0] entry_index;
    logic [2:0] day_of_week;
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
  } table_req_t;

  typedef struct packed {
    logic       accepted;
    logic       active;
    logic [2:0] match_index;
    logic [2:0] entry_count;
  } table_rsp_t;

  typedef struct {
    table_req_t req;
    bit         typed;
    table_rsp_t want;
  } directed_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  wtt_req_if req_if ();
  wtt_rsp_if rsp_if ();

  weekly_time_window_table_core i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the window table
  wtt_time_t     win_on  [CAPACITY];
  wtt_time_t     win_off [CAPACITY];
  int unsigned   win_count;
  table_rsp_t    pending_replies [$];
  directed_row_t directed_rows [$];
  int unsigned   errors       = 0;
  int unsigned   replies_seen = 0;
  bit            steady_flow  = 1'b0;

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic flag_error(string msg);
    errors++;
    $display("%0t ns  %s", $time, msg);
  endtask

  // Apply one request to the shadow table and form its reply
  function automatic table_rsp_t step_window_table(table_req_t r);
    table_rsp_t  res;
    int unsigned when_s;
    int unsigned i;
    bit          hit;
    res = '0;
    case (r.kind)
      KIND_ADD: begin
        if (win_count < CAPACITY) begin
          win_on[win_count]  = r.on_time;
          win_off[win_count] = r.off_time;
          win_count++;
          res.accepted = 1'b1;
        end
      end
      KIND_ERASE: begin
        if (r.entry_index < win_count) begin
          for (i = 32'(r.entry_index); i + 1 < win_count; i++) begin
            win_on[i]  = win_on[i + 1];
            win_off[i] = win_off[i + 1];
          end
          win_count--;
          res.accepted = 1'b1;
        end
      end
      KIND_QUERY: begin
        // No wrap modulo the week: out-of-range fields compare as formed
        when_s = r.day_of_week * DAY_S + r.hour_now * HOUR_S
               + r.minute_now * MIN_S + r.second_now;
        res.accepted = 1'b1;
        for (i = 0; i < win_count && !res.active; i++) begin
          // A window with off below on wraps around the week
          if (win_off[i] < win_on[i])
            hit = (when_s > win_on[i]) || (when_s < win_off[i]);
          else
            hit = (when_s > win_on[i]) && (when_s < win_off[i]);
          if (hit) begin
            res.active      = 1'b1;
            res.match_index = 3'(i);
          end
        end
      end
      default: ;
    endcase
    res.entry_count = 3'(win_count);
    return res;
  endfunction

  function automatic table_req_t add_req(wtt_time_t on_t, wtt_time_t off_t);
    table_req_t r;
    r          = '0;
    r.kind     = KIND_ADD;
    r.on_time  = on_t;
    r.off_time = off_t;
    return r;
  endfunction

  function automatic table_req_t erase_req(logic [2:0] idx);
    table_req_t r;
    r             = '0;
    r.kind        = KIND_ERASE;
    r.entry_index = idx;
    return r;
  endfunction

  function automatic table_req_t query_req(logic [2:0] d, logic [4:0] h,
                                           logic [5:0] m, logic [5:0] s);
    table_req_t r;
    r             = '0;
    r.kind        = KIND_QUERY;
    r.day_of_week = d;
    r.hour_now    = h;
    r.minute_now  = m;
    r.second_now  = s;
    return r;
  endfunction

  function automatic table_rsp_t reply(bit acc, bit act, logic [2:0] m, logic [2:0] c);
    table_rsp_t res;
    res.accepted    = acc;
    res.active      = act;
    res.match_index = m;
    res.entry_count = c;
    return res;
  endfunction

  task automatic plan(table_req_t r, bit typed = 1'b0, table_rsp_t want = '0);
    directed_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Drive one request, record its reply once accepted, then maybe pause
  task automatic issue(table_req_t r, bit typed, table_rsp_t want);
    table_rsp_t predicted;
    req_if.valid       <= 1'b1;
    req_if.kind        <= r.kind;
    req_if.on_time     <= r.on_time;
    req_if.off_time    <= r.off_time;
    req_if.entry_index <= r.entry_index;
    req_if.day_of_week <= r.day_of_week;
    req_if.hour_now    <= r.hour_now;
    req_if.minute_now  <= r.minute_now;
    req_if.second_now  <= r.second_now;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predicted = step_window_table(r);
    pending_replies.push_back(typed ? want : predicted);
    if (!steady_flow && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stall the reply channel in random bursts
  initial begin : reply_sink
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!steady_flow && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Compare each reply with the oldest pending one
  always @(posedge clk) begin : reply_check
    table_rsp_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("reply %0d arrived with no request pending", replies_seen));
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.accepted !== want.accepted)
          flag_error($sformatf("reply %0d accepted %b, want %b",
                               replies_seen, rsp_if.accepted, want.accepted));
        if (rsp_if.active !== want.active)
          flag_error($sformatf("reply %0d active %b, want %b",
                               replies_seen, rsp_if.active, want.active));
        if (rsp_if.match_index !== want.match_index)
          flag_error($sformatf("reply %0d match_index %0d, want %0d",
                               replies_seen, rsp_if.match_index, want.match_index));
        if (rsp_if.entry_count !== want.entry_count)
          flag_error($sformatf("reply %0d entry_count %0d, want %0d",
                               replies_seen, rsp_if.entry_count, want.entry_count));
      end
    end
  end

  initial begin : stimulus
    table_req_t r;
    int         n;
    int         i;
    int         pick;
    int         mode;
    int         e;
    int         s;
    int         add_share;
    int         erase_share;

    req_if.valid       <= 1'b0;
    req_if.kind        <= KIND_ADD;
    req_if.on_time     <= '0;
    req_if.off_time    <= '0;
    req_if.entry_index <= '0;
    req_if.day_of_week <= '0;
    req_if.hour_now    <= '0;
    req_if.minute_now  <= '0;
    req_if.second_now  <= '0;

    // Load the preset windows into the shadow table
    for (i = 0; i < CAPACITY; i++) begin
      win_on[i]  = '0;
      win_off[i] = '0;
    end
    win_count = (CAPACITY < 4) ? CAPACITY : 4;
    for (i = 0; i < win_count; i++) begin
      case (i)
        0: begin
          win_on[i]  = wtt_time_t'(3 * DAY_S + 22 * HOUR_S);
          win_off[i] = wtt_time_t'(4 * DAY_S);
        end
        1: begin
          win_on[i]  = wtt_time_t'(5 * DAY_S + 22 * HOUR_S);
          win_off[i] = wtt_time_t'(6 * DAY_S + 30 * MIN_S);
        end
        2: begin
          win_on[i]  = wtt_time_t'(6 * DAY_S + 22 * HOUR_S);
          win_off[i] = wtt_time_t'(30 * MIN_S);
        end
        default: begin
          win_on[i]  = wtt_time_t'(22 * HOUR_S);
          win_off[i] = wtt_time_t'(23 * HOUR_S + 30 * MIN_S);
        end
      endcase
    end

    // Directed rows: presets at their edges, the wrapping preset, extremes,
    // the unused kind, full table, out-of-range erase
    plan(query_req(3, 22, 0, 0), 1'b1, reply(1, 0, 0, 4));
    plan(query_req(3, 22, 0, 1), 1'b1, reply(1, 1, 0, 4));
    plan(query_req(6, 23, 59, 59), 1'b1, reply(1, 1, 2, 4));
    plan(query_req(0, 0, 0, 0), 1'b1, reply(1, 1, 2, 4));
    plan(query_req(0, 22, 30, 0), 1'b1, reply(1, 1, 3, 4));
    plan(query_req(0, 23, 30, 0), 1'b1, reply(1, 0, 0, 4));
    r             = query_req(7, 31, 63, 63);
    r.kind        = KIND_UNUSED;
    r.on_time     = '1;
    r.off_time    = '1;
    r.entry_index = '1;
    plan(r, 1'b1, reply(0, 0, 0, 4));
    plan(query_req(7, 31, 63, 63), 1'b1, reply(1, 1, 2, 4));
    plan(erase_req(7), 1'b1, reply(0, 0, 0, 4));
    plan(erase_req(4), 1'b1, reply(0, 0, 0, 4));
    plan(add_req(0, 0), 1'b1, reply(1, 0, 0, 5));
    plan(add_req('1, 0), 1'b1, reply(1, 0, 0, 6));
    plan(add_req(100, 200), 1'b1, reply(1, 0, 0, 7));
    plan(add_req(wtt_time_t'(WEEK_LAST), wtt_time_t'(WEEK_LAST)), 1'b1, reply(0, 0, 0, 7));
    plan(query_req(0, 0, 1, 0));
    plan(erase_req(2), 1'b1, reply(1, 0, 0, 6));
    plan(query_req(0, 0, 2, 30));
    plan(query_req(0, 0, 1, 40));
    plan(erase_req(6), 1'b1, reply(0, 0, 0, 6));
    plan(erase_req(5), 1'b1, reply(1, 0, 0, 5));
    plan(query_req(6, 23, 59, 59));
    plan(add_req(500000, 1), 1'b1, reply(1, 0, 0, 6));
    plan(query_req(0, 0, 0, 0));
    plan(erase_req(0), 1'b1, reply(1, 0, 0, 5));
    plan(query_req(5, 22, 0, 1));

    wait (rst_n === 1'b1);
    @(posedge clk);

    foreach (directed_rows[k])
      issue(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want);

    // Random requests: alternate fill-heavy and drain-heavy stretches
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= RANDOM_ITEMS - CALM_ITEMS) || ((n / 64) % 3 == 2);
      add_share   = ((n / 40) % 2 == 0) ? 40 : 15;
      erase_share = ((n / 40) % 2 == 0) ? 12 : 35;

      // Start from full-width noise in every field but the kind
      r.kind        = KIND_QUERY;
      r.on_time     = wtt_time_t'($urandom);
      r.off_time    = wtt_time_t'($urandom);
      r.entry_index = 3'($urandom);
      r.day_of_week = 3'($urandom);
      r.hour_now    = 5'($urandom);
      r.minute_now  = 6'($urandom);
      r.second_now  = 6'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        r.kind = KIND_UNUSED;
      end else if (pick < 4 + add_share) begin
        r.kind = KIND_ADD;
        case ($urandom_range(0, 9))
          0: ;
          1: r.off_time = r.on_time;
          2: begin
            r.on_time  = wtt_time_t'(WEEK_LAST);
            r.off_time = '0;
          end
          default: begin
            r.on_time  = wtt_time_t'($urandom_range(0, WEEK_LAST));
            r.off_time = wtt_time_t'($urandom_range(0, WEEK_LAST));
          end
        endcase
      end else if (pick < 4 + add_share + erase_share) begin
        r.kind = KIND_ERASE;
        if (win_count > 0 && $urandom_range(0, 4) != 0)
          r.entry_index = 3'($urandom_range(0, win_count - 1));
      end else begin
        mode = $urandom_range(0, 9);
        if (mode >= 5 && win_count > 0) begin
          // Land on or next to a stored window edge
          e = $urandom_range(0, win_count - 1);
          s = ($urandom_range(0, 1) != 0) ? int'(win_on[e]) : int'(win_off[e]);
          s = s + $urandom_range(0, 2) - 1;
          if (s >= 0 && s < 8 * DAY_S) begin
            r.day_of_week = 3'(s / DAY_S);
            r.hour_now    = 5'((s % DAY_S) / HOUR_S);
            r.minute_now  = 6'((s % HOUR_S) / MIN_S);
            r.second_now  = 6'(s % MIN_S);
          end
        end else if (mode >= 1) begin
          r.day_of_week = 3'($urandom_range(0, 6));
          r.hour_now    = 5'($urandom_range(0, 23));
          r.minute_now  = 6'($urandom_range(0, 59));
          r.second_now  = 6'($urandom_range(0, 59));
        end
      end
      issue(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;

    // Drain outstanding replies, then idle before the verdict
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
